### rtl/mhlt_pkg.sv
// Types, codes and constant tables shared by the header/length/tail deframer.
package mhlt_pkg;

  localparam int FRAME_OVERHEAD = 10;
  localparam int LEN_W = 7;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_DATA  = 2'd1;
  localparam logic [1:0] EV_EMPTY = 2'd2;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic [15:0] GAP_LIMIT_RESET = 16'd100;

  // Entry 0 is the first byte on the wire.
  localparam logic [3:0][7:0] MAGIC_ACK    = {8'hFA, 8'hFB, 8'hFC, 8'hFD};
  localparam logic [3:0][7:0] MAGIC_REPORT = {8'hF1, 8'hF2, 8'hF3, 8'hF4};
  localparam logic [3:0][7:0] TAIL_ACK     = {8'h01, 8'h02, 8'h03, 8'h04};
  localparam logic [3:0][7:0] TAIL_REPORT  = {8'hF5, 8'hF6, 8'hF7, 8'hF8};

  typedef enum logic [3:0] {
    PH_SCAN = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_TAIL = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_LOAD  = 3'b100
  } emit_state_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data_byte;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  frame_kind_out;
    logic [5:0]  payload_length;
    logic [5:0]  byte_index;
    logic [7:0]  frame_byte;
    logic        last;
    logic [31:0] ok_count;
    logic [31:0] error_count;
    logic [31:0] resync_count;
    logic [31:0] timeout_count;
  } result_t;

  typedef struct packed {
    logic [31:0] ok;
    logic [31:0] error;
    logic [31:0] resync;
    logic [31:0] timeout;
  } counts_t;

  // One unit of work for the emitter: a plain status word, an empty frame
  // or a frame whose data sits in the frame store.
  typedef struct packed {
    logic [1:0]       ev;
    logic [1:0]       kind;
    logic [LEN_W-1:0] len;
    counts_t          counts;
  } job_t;

  function automatic logic [7:0] tail_byte(input logic [1:0] kind, input logic [1:0] idx);
    tail_byte = (kind == KIND_ACK) ? TAIL_ACK[idx] : TAIL_REPORT[idx];
  endfunction

endpackage

### rtl/magic_header_length_tail_deframer.sv
// Top level of the header/length/tail deframer: front end, job queue, emitter, frame store.
//
//   channel  | signals                            | word
//   ---------+------------------------------------+-----------------------------------
//   item     | item_valid, item_ready, item       | item_t: cmd, data_byte, now_ms
//   result   | result_valid, result_ready, result | result_t: event, frame, counters
//   cfg      | cfg_valid, cfg_ready, cfg_data     | gap_limit_ms, 16 bits, always ready
//
// The front end takes one word per cycle while the queue has room and no frame read-out
// holds it off, and hands one job per word to a two-entry queue. The emitter turns a
// status job into one result word; for a data job it reads the registered store in a
// fetch state, then a load state puts out one word per byte. Data words of a new frame
// are held off while a frame is still being read out, since both use the one frame store.
// rst is synchronous and clears phase, counters, queue and emitter; gap_limit_ms
// returns to 100. Either side may stall; the queue and the output register decouple them.
module magic_header_length_tail_deframer import mhlt_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int DATA_CAP = MAX_FRAME_BYTES - FRAME_OVERHEAD;
  localparam int ADDR_W = (DATA_CAP > 1) ? $clog2(DATA_CAP) : 1;

  logic [15:0]       gap_limit;
  logic              q_push_valid;
  logic              q_push_ready;
  job_t              q_push_job;
  logic              q_pop_valid;
  logic              q_pop;
  job_t              q_pop_job;
  logic              back_busy;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= GAP_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gap_limit <= cfg_data;
    end
  end

  mhlt_front #(
    .DATA_CAP (DATA_CAP),
    .ADDR_W   (ADDR_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .gap_limit  (gap_limit),
    .emit_busy  (back_busy || q_pop_valid),
    .job_valid  (q_push_valid),
    .job_ready  (q_push_ready),
    .job        (q_push_job),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  mhlt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop),
    .pop_job    (q_pop_job)
  );

  mhlt_ram #(
    .WIDTH (8),
    .DEPTH (DATA_CAP),
    .AW    (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mhlt_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_pop_valid),
    .job_pop      (q_pop),
    .job          (q_pop_job),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .busy         (back_busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push_valid |-> q_push_ready)
    else $error("job pushed into a full queue");

  a_store_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !back_busy && !q_pop_valid)
    else $error("frame store written while a frame is being read out");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.event_res != EV_DATA) |-> result.last)
    else $error("status word without last");

  a_pop_starts_emit: assert property (@(posedge clk) disable iff (rst)
    q_pop && (q_pop_job.ev == EV_DATA) |=> back_busy)
    else $error("data job popped without starting the emitter");

endmodule

### rtl/mhlt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 54,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/mhlt_front.sv
// Front end: takes words, hunts the header, checks length and tail, keeps the counters.
module mhlt_front import mhlt_pkg::*; #(
  parameter int DATA_CAP = 54,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  input  logic [15:0]       gap_limit,
  input  logic              emit_busy,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]        ram_wdata
);

  phase_t      phase, phase_next;
  logic [1:0]  kind, kind_next;
  logic [5:0]  position, position_next;
  logic [15:0] length_word, length_word_next;
  logic [7:0]  window [3];
  logic [7:0]  window_next [3];
  logic [31:0] last_time, last_time_next;
  logic        tail_ok, tail_ok_next;
  counts_t     counts, counts_next;

  logic        accept;
  logic [31:0] gap;
  logic [15:0] len_full;
  logic [6:0]  pos_inc;
  logic        tail_match;
  logic        tail_all;
  logic [7:0]  b;

  // Hold off data words while the store is still being read out.
  assign item_ready = job_ready && !((phase == PH_DATA) && emit_busy);
  assign accept     = item_valid && item_ready;
  assign job_valid  = accept;

  assign b          = item.data_byte;
  assign gap        = item.now_ms - last_time;
  assign len_full   = {b, length_word[7:0]};
  assign pos_inc    = {1'b0, position} + 7'd1;
  assign tail_match = (b == tail_byte(kind, position[1:0]));
  assign tail_all   = tail_ok && tail_match;

  assign ram_waddr = position[ADDR_W-1:0];
  assign ram_wdata = b;

  always_comb begin
    phase_next       = phase;
    kind_next        = kind;
    position_next    = position;
    length_word_next = length_word;
    window_next      = window;
    last_time_next   = last_time;
    tail_ok_next     = tail_ok;
    counts_next      = counts;
    ram_we           = 1'b0;
    job.ev           = EV_NONE;
    job.kind         = KIND_NONE;
    job.len          = '0;

    if (item.cmd == CMD_TICK) begin
      if ((phase != PH_SCAN) && (gap > {16'd0, gap_limit})) begin
        counts_next.timeout = counts.timeout + 32'd1;
        phase_next       = PH_SCAN;
        kind_next        = KIND_NONE;
        position_next    = '0;
        length_word_next = '0;
      end
    end else begin
      last_time_next = item.now_ms;
      case (phase)
        PH_SCAN: begin
          if (position < 6'd3) begin
            window_next[position[1:0]] = b;
            position_next = position + 6'd1;
          end else if (window[0] == MAGIC_ACK[0] && window[1] == MAGIC_ACK[1] &&
                       window[2] == MAGIC_ACK[2] && b == MAGIC_ACK[3]) begin
            kind_next     = KIND_ACK;
            phase_next    = PH_LEN;
            position_next = '0;
          end else if (window[0] == MAGIC_REPORT[0] && window[1] == MAGIC_REPORT[1] &&
                       window[2] == MAGIC_REPORT[2] && b == MAGIC_REPORT[3]) begin
            kind_next     = KIND_REPORT;
            phase_next    = PH_LEN;
            position_next = '0;
          end else begin
            // Slip the window by one word.
            window_next[0] = window[1];
            window_next[1] = window[2];
            window_next[2] = b;
            counts_next.resync = counts.resync + 32'd1;
          end
        end
        PH_LEN: begin
          if (position == 6'd0) begin
            length_word_next = {8'd0, b};
            position_next    = 6'd1;
          end else if (len_full > 16'(DATA_CAP)) begin
            counts_next.error = counts.error + 32'd1;
            phase_next       = PH_SCAN;
            kind_next        = KIND_NONE;
            position_next    = '0;
            length_word_next = '0;
          end else begin
            length_word_next = len_full;
            position_next    = '0;
            tail_ok_next     = 1'b1;
            phase_next       = (len_full == 16'd0) ? PH_TAIL : PH_DATA;
          end
        end
        PH_DATA: begin
          ram_we        = accept;
          position_next = pos_inc[5:0];
          if ({9'd0, pos_inc} >= length_word) begin
            phase_next    = PH_TAIL;
            position_next = '0;
            tail_ok_next  = 1'b1;
          end
        end
        PH_TAIL: begin
          tail_ok_next  = tail_all;
          position_next = position + 6'd1;
          if (position == 6'd3) begin
            if (tail_all) begin
              counts_next.ok = counts.ok + 32'd1;
              job.ev   = (length_word == 16'd0) ? EV_EMPTY : EV_DATA;
              job.kind = kind;
              job.len  = length_word[LEN_W-1:0];
            end else begin
              counts_next.error = counts.error + 32'd1;
            end
            phase_next       = PH_SCAN;
            kind_next        = KIND_NONE;
            position_next    = '0;
            length_word_next = '0;
          end
        end
        default: begin
          phase_next    = PH_SCAN;
          position_next = '0;
        end
      endcase
    end
    job.counts = counts_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SCAN;
      kind        <= KIND_NONE;
      position    <= '0;
      length_word <= '0;
      last_time   <= '0;
      tail_ok     <= 1'b1;
      counts      <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      kind        <= kind_next;
      position    <= position_next;
      length_word <= length_word_next;
      last_time   <= last_time_next;
      tail_ok     <= tail_ok_next;
      counts      <= counts_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

### rtl/mhlt_queue.sv
// Two-entry job queue between the front end and the emitter.
module mhlt_queue import mhlt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t       entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

endmodule

### rtl/mhlt_back.sv
// Emitter: turns jobs into result words, walking the frame store for data frames.
module mhlt_back import mhlt_pkg::*; #(
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_pop,
  input  job_t              job,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              busy,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result
);

  emit_state_t      state;
  job_t             cur;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] idx_inc;
  logic             is_last;
  logic             out_free;
  logic             load_byte;
  result_t          res_status;
  result_t          res_byte;

  assign out_free  = !result_valid || result_ready;
  assign job_pop   = (state == ST_IDLE) && job_valid && ((job.ev == EV_DATA) || out_free);
  assign idx_inc   = idx + LEN_W'(1);
  assign is_last   = (idx_inc == cur.len);
  assign load_byte = (state == ST_LOAD) && out_free;
  assign busy      = (state != ST_IDLE);

  // Advance the read address as soon as the current word is taken.
  assign ram_raddr = (load_byte && !is_last) ? idx_inc[ADDR_W-1:0] : idx[ADDR_W-1:0];

  always_comb begin
    res_status                = '0;
    res_status.event_res      = job.ev;
    res_status.frame_kind_out = (job.ev == EV_EMPTY) ? job.kind : KIND_NONE;
    res_status.last           = 1'b1;
    res_status.ok_count       = job.counts.ok;
    res_status.error_count    = job.counts.error;
    res_status.resync_count   = job.counts.resync;
    res_status.timeout_count  = job.counts.timeout;

    res_byte.event_res      = EV_DATA;
    res_byte.frame_kind_out = cur.kind;
    res_byte.payload_length = cur.len[5:0];
    res_byte.byte_index     = idx[5:0];
    res_byte.frame_byte     = ram_rdata;
    res_byte.last           = is_last;
    res_byte.ok_count       = cur.counts.ok;
    res_byte.error_count    = cur.counts.error;
    res_byte.resync_count   = cur.counts.resync;
    res_byte.timeout_count  = cur.counts.timeout;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_pop) begin
            if (job.ev == EV_DATA) begin
              state <= ST_FETCH;
            end else begin
              result_valid <= 1'b1;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            result_valid <= 1'b1;
            if (is_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
      idx <= '0;
      if (job.ev != EV_DATA) begin
        result <= res_status;
      end
    end else if (load_byte) begin
      result <= res_byte;
      idx    <= idx_inc;
    end
  end

endmodule

### test/deframer_checker.sv
// Checker for the deframer: watches all channels, predicts each result word and compares.
`timescale 1ns / 100ps

module deframer_checker import mhlt_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_ready,
  input  result_t     result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          results_due
);

  localparam int DATA_OFFSET = 6;
  localparam int LEN_LIMIT = MAX_FRAME_BYTES - FRAME_OVERHEAD;

  logic [15:0] gap_ms;
  phase_t      ph;
  logic [1:0]  kind;
  int unsigned pos;
  logic [15:0] len_word;
  logic [7:0]  hdr_win [3];
  logic [7:0]  store [MAX_FRAME_BYTES];
  logic [31:0] last_rx_ms;
  counts_t     totals;
  result_t     due_results [$];
  int          bad_words = 0;

  function automatic void restart_frame();
    ph = PH_SCAN;
    kind = KIND_NONE;
    pos = 0;
    len_word = '0;
  endfunction

  function automatic result_t result_word(logic [1:0] ev, logic [1:0] kind_o,
                                          logic [5:0] len_o, logic [5:0] idx,
                                          logic [7:0] dbyte, logic fin);
    result_t w;
    w.event_res = ev;
    w.frame_kind_out = kind_o;
    w.payload_length = len_o;
    w.byte_index = idx;
    w.frame_byte = dbyte;
    w.last = fin;
    w.ok_count = totals.ok;
    w.error_count = totals.error;
    w.resync_count = totals.resync;
    w.timeout_count = totals.timeout;
    return w;
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("ev=%0d kind=%0d len=%0d idx=%0d byte=%02h last=%0d ok=%0d err=%0d resync=%0d tmo=%0d",
                     r.event_res, r.frame_kind_out, r.payload_length, r.byte_index,
                     r.frame_byte, r.last, r.ok_count, r.error_count, r.resync_count,
                     r.timeout_count);
  endfunction

  function automatic bit hdr_match(logic [3:0][7:0] magic, logic [7:0] b);
    return hdr_win[0] == magic[0] && hdr_win[1] == magic[1] &&
           hdr_win[2] == magic[2] && b == magic[3];
  endfunction

  // Returns 1 when this byte closes a frame with a good tail.
  function automatic bit absorb_byte(logic [7:0] b);
    logic [3:0][7:0] tail;
    bit good;
    int i;
    good = 1'b0;
    case (ph)
      PH_SCAN: begin
        if (pos < 3) begin
          hdr_win[pos] = b;
          pos++;
        end else if (hdr_match(MAGIC_ACK, b)) begin
          kind = KIND_ACK;
          ph = PH_LEN;
          pos = 0;
        end else if (hdr_match(MAGIC_REPORT, b)) begin
          kind = KIND_REPORT;
          ph = PH_LEN;
          pos = 0;
        end else begin
          // slip the window by one byte
          hdr_win[0] = hdr_win[1];
          hdr_win[1] = hdr_win[2];
          hdr_win[2] = b;
          totals.resync = totals.resync + 1'b1;
        end
      end
      PH_LEN: begin
        if (pos == 0) begin
          len_word = {8'd0, b};
          pos = 1;
        end else begin
          len_word = {b, len_word[7:0]};
          if (len_word > LEN_LIMIT) begin
            totals.error = totals.error + 1'b1;
            restart_frame();
          end else begin
            pos = 0;
            if (len_word == 0) ph = PH_TAIL;
            else ph = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        store[DATA_OFFSET + pos] = b;
        pos++;
        if (pos >= len_word) begin
          ph = PH_TAIL;
          pos = 0;
        end
      end
      default: begin
        store[DATA_OFFSET + len_word + pos] = b;
        pos++;
        if (pos >= 4) begin
          tail = (kind == KIND_ACK) ? TAIL_ACK : TAIL_REPORT;
          good = 1'b1;
          for (i = 0; i < 4; i++)
            if (store[DATA_OFFSET + len_word + i] != tail[i]) good = 1'b0;
          if (good) begin
            totals.ok = totals.ok + 1'b1;
          end else begin
            totals.error = totals.error + 1'b1;
            restart_frame();
          end
        end
      end
    endcase
    return good;
  endfunction

  task automatic deframe_item(input item_t it);
    logic [1:0]  k;
    logic [15:0] n;
    int          i;
    if (it.cmd == CMD_TICK) begin
      if (ph != PH_SCAN && (it.now_ms - last_rx_ms) > {16'd0, gap_ms}) begin
        totals.timeout = totals.timeout + 1'b1;
        restart_frame();
      end
      due_results.push_back(result_word(EV_NONE, KIND_NONE, '0, '0, '0, 1'b1));
    end else begin
      last_rx_ms = it.now_ms;
      if (absorb_byte(it.data_byte)) begin
        k = kind;
        n = len_word;
        restart_frame();
        if (n == 0) begin
          due_results.push_back(result_word(EV_EMPTY, k, '0, '0, '0, 1'b1));
        end else begin
          for (i = 0; i < n; i++)
            due_results.push_back(result_word(EV_DATA, k, n[5:0], 6'(i),
                                              store[DATA_OFFSET + i], i + 1 == n));
        end
      end else begin
        due_results.push_back(result_word(EV_NONE, KIND_NONE, '0, '0, '0, 1'b1));
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      gap_ms = GAP_LIMIT_RESET;
      restart_frame();
      last_rx_ms = '0;
      totals = '0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) gap_ms = cfg_data;
      if (item_valid && item_ready) deframe_item(item);
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          bad_words++;
          $display("%0t: unexpected result word, expected none, got %s", $time,
                   describe(result));
        end else begin
          want = due_results.pop_front();
          if (result !== want) begin
            bad_words++;
            $display("%0t: result mismatch, expected %s, got %s", $time,
                     describe(want), describe(result));
          end
        end
      end
    end
    results_due <= due_results.size();
    mismatch_count <= bad_words;
  end

endmodule

### test/magic_header_length_tail_deframer_tb.sv
// Testbench top for the deframer: drives bytes, ticks and gap limit writes, gives the verdict.
`timescale 1ns / 100ps

module magic_header_length_tail_deframer_tb;
  import mhlt_pkg::*;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int LEN_LIMIT = MAX_FRAME_BYTES - FRAME_OVERHEAD;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int END_WAIT_LIMIT = 100000;

  typedef enum {FR_GOOD, FR_BAD_TAIL, FR_ABORT} frame_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       item = '0;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int          mismatch_count;
  int          results_due;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          items_sent = 0;
  logic [15:0] gap_now = GAP_LIMIT_RESET;
  logic [31:0] stamp_ms = '0;
  logic [7:0]  body_bytes [$];

  magic_header_length_tail_deframer #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  deframer_checker #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .results_due(results_due)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      result_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic offer(input item_t it);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    stamp_ms = stamp_ms + $urandom_range(30);
    offer('{cmd: CMD_BYTE, data_byte: b, now_ms: stamp_ms});
  endtask

  // An aborting tick lands past the gap limit; a quiet one stays within it.
  task automatic send_tick(input bit abort);
    logic [31:0] delta;
    if (abort) delta = {16'd0, gap_now} + 32'd1 + $urandom_range(500);
    else delta = $urandom_range({16'd0, gap_now});
    offer('{cmd: CMD_TICK, data_byte: 8'($urandom_range(255)), now_ms: stamp_ms + delta});
    if (abort) stamp_ms = stamp_ms + delta;
  endtask

  // Data comes from body_bytes; len_word above the limit sends only header and length.
  task automatic send_frame(input logic [1:0] kind, input logic [15:0] len_word,
                            input frame_mode_t mode);
    logic [7:0]      wire_bytes [$];
    logic [3:0][7:0] magic;
    logic [3:0][7:0] tail;
    int              tick_at;
    int              idx;
    int              i;
    magic = (kind == KIND_ACK) ? MAGIC_ACK : MAGIC_REPORT;
    tail = (kind == KIND_ACK) ? TAIL_ACK : TAIL_REPORT;
    for (i = 0; i < 4; i++) wire_bytes.push_back(magic[i]);
    wire_bytes.push_back(len_word[7:0]);
    wire_bytes.push_back(len_word[15:8]);
    if (len_word <= LEN_LIMIT) begin
      foreach (body_bytes[j]) wire_bytes.push_back(body_bytes[j]);
      for (i = 0; i < 4; i++) wire_bytes.push_back(tail[i]);
      if (mode == FR_BAD_TAIL) begin
        idx = wire_bytes.size() - 1 - $urandom_range(3);
        wire_bytes[idx] = wire_bytes[idx] ^ 8'($urandom_range(255, 1));
      end
    end
    tick_at = -1;
    if (mode == FR_ABORT) tick_at = $urandom_range(wire_bytes.size() - 1, 4);
    else if ($urandom_range(9) == 0) tick_at = $urandom_range(wire_bytes.size() - 1);
    for (i = 0; i < wire_bytes.size(); i++) begin
      if (i == tick_at) begin
        send_tick(mode == FR_ABORT);
        // drop the rest of an aborted frame half the time
        if (mode == FR_ABORT && $urandom_range(1)) break;
      end
      send_byte(wire_bytes[i]);
    end
  endtask

  task automatic write_gap(input logic [15:0] v);
    item_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gap_now = v;
  endtask

  task automatic run_traffic(input int n_items);
    int          stop_at;
    int          r;
    int          n;
    logic [1:0]  kind;
    logic [15:0] bad_len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0) stamp_ms = $urandom_range(1) ? $urandom : 32'hFFFF_FFF0;
      if ($urandom_range(3) != 0) begin
        kind = $urandom_range(1) ? KIND_ACK : KIND_REPORT;
        if ($urandom_range(9) < 3)
          repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
        r = $urandom_range(99);
        if (r < 70) n = $urandom_range(8);
        else if (r < 90) n = $urandom_range(30, 9);
        else n = $urandom_range(LEN_LIMIT, 31);
        body_bytes.delete();
        repeat (n) body_bytes.push_back(8'($urandom_range(255)));
        r = $urandom_range(99);
        if (r < 65) begin
          send_frame(kind, 16'(n), FR_GOOD);
        end else if (r < 77) begin
          send_frame(kind, 16'(n), FR_BAD_TAIL);
        end else if (r < 87) begin
          r = $urandom_range(99);
          if (r < 50) bad_len = 16'($urandom_range(255, LEN_LIMIT + 1));
          else if (r < 80) bad_len = 16'($urandom_range(65535, 256));
          else bad_len = $urandom_range(1) ? 16'hFFFF : 16'(LEN_LIMIT + 1);
          send_frame(kind, bad_len, FR_GOOD);
        end else begin
          send_frame(kind, 16'(n), FR_ABORT);
        end
      end else begin
        repeat ($urandom_range(5, 1)) begin
          if ($urandom_range(3) == 0) send_tick($urandom_range(1));
          else if ($urandom_range(1)) send_byte(8'($urandom_range(255)));
          else send_byte($urandom_range(1) ? MAGIC_ACK[$urandom_range(3)]
                                           : MAGIC_REPORT[$urandom_range(3)]);
        end
      end
    end
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle = 31;
    recv_idle = 50;
    write_gap(16'd40);

    // directed: tick while scanning that carries the stamp across its wrap, empty ack frame,
    // report frame carrying the byte extremes
    stamp_ms = 32'hFFFF_FFFA;
    send_tick(1'b1);
    body_bytes.delete();
    send_frame(KIND_ACK, 16'd0, FR_GOOD);
    body_bytes = '{8'h00, 8'hFF};
    send_frame(KIND_REPORT, 16'd2, FR_GOOD);

    // hold the receiver off while a full-size frame goes in
    hold_reqs++;
    body_bytes.delete();
    repeat (LEN_LIMIT) body_bytes.push_back(8'($urandom_range(255)));
    send_frame(KIND_ACK, 16'(LEN_LIMIT), FR_GOOD);
    run_traffic(10);

    send_idle = 50;
    recv_idle = 31;
    write_gap(16'd0);
    run_traffic(20);

    send_idle = 0;
    recv_idle = 0;
    write_gap(16'hFFFF);
    run_traffic(15);
    write_gap(16'($urandom_range(65535)));
    run_traffic(10);

    item_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (results_due != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
